// ===== rtl/core/hcp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcp_pkg
// Types, constants and lookup tables for the humidity compensation pipeline.
// ----------------------------------------------------------------------------
package hcp_pkg;

  localparam int unsigned RAW_W   = 16;
  localparam int unsigned TEMP_W  = 12;
  localparam int unsigned HUM_W   = 10;
  localparam int unsigned AH_W    = 11;
  localparam int unsigned COMP_W  = 9;
  localparam int unsigned PIPE_N  = 8;

  localparam logic [14:0] TEMP_GAIN   = 15'd21875;
  localparam logic [18:0] TEMP_OFFSET = 19'd45000;
  localparam logic [13:0] HUM_GAIN    = 14'd12500;
  localparam logic [17:0] RECIP_100   = 18'd167773;     // ceil(2^24 / 100)
  localparam logic [14:0] TEMP_FUDGE  = 15'd8225;
  localparam logic [13:0] HUM_FUDGE   = 14'd8397;
  localparam logic [6:0]  NORM_GAIN   = 7'd82;
  localparam logic [19:0] OFFS_BIAS   = 20'd19500;      // -500 then +20000, wrap cancels
  localparam logic [19:0] TAB_STEP    = 20'd10000;
  localparam logic [19:0] TAB_LIMIT   = 20'd90000;
  localparam logic [29:0] RECIP_10K   = 30'd879609303;  // ceil(2^43 / 10000)
  localparam logic [21:0] RECIP_1000  = 22'd2147484;    // ceil(2^31 / 1000)
  localparam logic [17:0] TAB_LAST    = 18'd198277;
  localparam logic [14:0] COMP_GAIN   = 15'd16777;
  localparam logic [18:0] COMP_LIMIT  = 19'd256000;

  typedef struct packed {
    logic [RAW_W-1:0] raw_temp_word;
    logic [RAW_W-1:0] raw_hum_word;
  } hcp_in_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_deci_c;
    logic [HUM_W-1:0]         hum_deci_pct;
    logic [AH_W-1:0]          abs_hum_value;
    logic [COMP_W-1:0]        comp_word;
    logic                     comp_valid;
  } hcp_out_t;

  function automatic logic [17:0] ah_tab(input logic [3:0] seg);
    logic [17:0] v;
    case (seg)
      4'd0:    v = 18'd1078;
      4'd1:    v = 18'd2364;
      4'd2:    v = 18'd4849;
      4'd3:    v = 18'd9383;
      4'd4:    v = 18'd17243;
      4'd5:    v = 18'd30264;
      4'd6:    v = 18'd50983;
      4'd7:    v = 18'd82785;
      4'd8:    v = 18'd130048;
      default: v = TAB_LAST;
    endcase
    return v;
  endfunction

  function automatic logic [16:0] ah_diff(input logic [3:0] seg);
    logic [16:0] v;
    case (seg)
      4'd0:    v = 17'd1286;
      4'd1:    v = 17'd2485;
      4'd2:    v = 17'd4534;
      4'd3:    v = 17'd7860;
      4'd4:    v = 17'd13021;
      4'd5:    v = 17'd20719;
      4'd6:    v = 17'd31802;
      4'd7:    v = 17'd47263;
      4'd8:    v = 17'd68229;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/humidity_compensation_pipeline.sv =====
// ----------------------------------------------------------------------------
// humidity_compensation_pipeline
// Raw temperature/humidity pair to calibrated values and gas compensation word.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a raw sensor pair on sample and raise start; the beat is taken at
//   a rising edge with start high and busy low. One result beat per sample
//   appears on result, marked by strobe for exactly one cycle; result and
//   strobe are both registered by stage 8, in the same cycle.
//   The receiver must take it in that cycle.
//   Throughput is one sample per cycle while busy is low: eight register
//   stages, with at most one multiplier on any path through a stage
//   (conversions, reciprocal divisions by 100, 10000 and 1000, table
//   interpolation, compensation scaling).
//   Results leave in the order samples were taken.
//   Synchronous reset (rst) empties the pipeline, drops every beat in
//   flight and holds busy high until the first clock edge with rst low;
//   busy is low at all other times.
// ----------------------------------------------------------------------------
module humidity_compensation_pipeline (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  hcp_pkg::hcp_in_t sample,
  output logic             strobe,
  output hcp_pkg::hcp_out_t result
);
  import hcp_pkg::*;

  logic [PIPE_N-1:0] vld;

  // stage 1
  logic [30:0]        m1_t;
  logic [29:0]        m1_h;
  logic signed [18:0] td;
  logic [16:0]        td_mag;
  logic               s1_neg;
  logic [16:0]        s1_tmag;
  logic [16:0]        s1_h;

  // stage 2
  logic [34:0]              m2_t;
  logic [34:0]              m2_h;
  logic [TEMP_W-1:0]        tq;
  logic signed [TEMP_W-1:0] s2_temp;
  logic [HUM_W-1:0]         s2_hum;

  // stage 3
  logic signed [26:0]       m3_t;
  logic [31:0]              t_word;
  logic [23:0]              m3_h;
  logic signed [TEMP_W-1:0] s3_temp;
  logic [HUM_W-1:0]         s3_hum;
  logic [19:0]              s3_offs;
  logic [9:0]               s3_hs;

  // stage 4
  logic [3:0]               seg;
  logic [16:0]              rem_w;
  logic [30:0]              m4_p;
  logic [16:0]              m4_n;
  logic signed [TEMP_W-1:0] s4_temp;
  logic [HUM_W-1:0]         s4_hum;
  logic [3:0]               s4_seg;
  logic                     s4_clamp;
  logic [29:0]              s4_prod;
  logic [3:0]               s4_norm;
  logic                     s4_hz;

  // stage 5
  logic [59:0]              m5_i;
  logic signed [TEMP_W-1:0] s5_temp;
  logic [HUM_W-1:0]         s5_hum;
  logic [17:0]              s5_base;
  logic [3:0]               s5_norm;
  logic                     s5_hz;

  // stage 6
  logic signed [TEMP_W-1:0] s6_temp;
  logic [HUM_W-1:0]         s6_hum;
  logic [21:0]              s6_x;
  logic                     s6_hz;

  // stage 7
  logic [43:0]              m7_q;
  logic signed [TEMP_W-1:0] s7_temp;
  logic [HUM_W-1:0]         s7_hum;
  logic [AH_W-1:0]          s7_ah;

  // stage 8
  logic [25:0]              m8_c;
  logic                     ah_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      vld  <= '0;
    end else begin
      busy <= 1'b0;
      vld  <= {vld[PIPE_N-2:0], start & ~busy};
    end
  end

  assign strobe = vld[PIPE_N-1];

  // stage 1: raw to scaled units, temperature offset, magnitude
  assign m1_t   = 31'(sample.raw_temp_word) * 31'(TEMP_GAIN);
  assign m1_h   = 30'(sample.raw_hum_word) * 30'(HUM_GAIN);
  assign td     = $signed({1'b0, m1_t[30:13]}) - $signed(TEMP_OFFSET);
  assign td_mag = td[18] ? 17'(-td) : td[16:0];

  always_ff @(posedge clk) begin
    s1_neg  <= td[18];
    s1_tmag <= td_mag;
    s1_h    <= m1_h[29:13];
  end

  // stage 2: divide by 100, truncating toward zero
  assign m2_t = 35'(s1_tmag) * 35'(RECIP_100);
  assign m2_h = 35'(s1_h) * 35'(RECIP_100);
  assign tq   = {1'b0, m2_t[34:24]};

  always_ff @(posedge clk) begin
    s2_temp <= s1_neg ? -$signed(tq) : $signed(tq);
    s2_hum  <= m2_h[33:24];
  end

  // stage 3: fudge factors, 32-bit wrap, table offset
  assign m3_t   = s2_temp * $signed({12'd0, TEMP_FUDGE});
  assign t_word = {{5{m3_t[26]}}, m3_t};
  assign m3_h   = 24'(s2_hum) * 24'(HUM_FUDGE);

  always_ff @(posedge clk) begin
    s3_temp <= s2_temp;
    s3_hum  <= s2_hum;
    s3_offs <= {1'b0, t_word[31:13]} + OFFS_BIAS;
    s3_hs   <= m3_h[22:13];
  end

  // stage 4: segment, remainder, slope product, normalized humidity
  always_comb begin
    seg = 4'd0;
    for (int i = 1; i <= 8; i++) begin
      if (s3_offs >= 20'(i) * TAB_STEP) begin
        seg = 4'(i);
      end
    end
  end

  assign rem_w = s3_offs[16:0] - 17'(20'(seg) * TAB_STEP);
  assign m4_p  = 31'(ah_diff(seg)) * 31'(rem_w[13:0]);
  assign m4_n  = 17'(s3_hs) * 17'(NORM_GAIN);

  always_ff @(posedge clk) begin
    s4_temp  <= s3_temp;
    s4_hum   <= s3_hum;
    s4_seg   <= seg;
    s4_clamp <= s3_offs >= TAB_LIMIT;
    s4_prod  <= m4_p[29:0];
    s4_norm  <= m4_n[16:13];
    s4_hz    <= s3_hs == 10'd0;
  end

  // stage 5: divide slope product by step, add segment base, clamp at table limit
  assign m5_i = 60'(s4_prod) * 60'(RECIP_10K);

  always_ff @(posedge clk) begin
    s5_temp <= s4_temp;
    s5_hum  <= s4_hum;
    s5_base <= s4_clamp ? TAB_LAST : ah_tab(s4_seg) + 18'(m5_i[59:43]);
    s5_norm <= s4_norm;
    s5_hz   <= s4_hz;
  end

  // stage 6: scale by normalized humidity
  always_ff @(posedge clk) begin
    s6_temp <= s5_temp;
    s6_hum  <= s5_hum;
    s6_x    <= 22'(s5_base) * 22'(s5_norm);
    s6_hz   <= s5_hz;
  end

  // stage 7: divide by 1000, zero humidity gives zero
  assign m7_q = 44'(s6_x) * 44'(RECIP_1000);

  always_ff @(posedge clk) begin
    s7_temp <= s6_temp;
    s7_hum  <= s6_hum;
    s7_ah   <= s6_hz ? '0 : m7_q[41:31];
  end

  // stage 8: compensation word and range flag
  assign m8_c  = 26'(s7_ah) * 26'(COMP_GAIN);
  assign ah_ok = 19'(s7_ah) < COMP_LIMIT;

  always_ff @(posedge clk) begin
    result.temp_deci_c   <= s7_temp;
    result.hum_deci_pct  <= s7_hum;
    result.abs_hum_value <= s7_ah;
    result.comp_word     <= ah_ok ? m8_c[24:16] : '0;
    result.comp_valid    <= ah_ok;
  end

endmodule
